// ===== rtl/core/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator: pool sizes,
// command and status codes, pool select and decode result types.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int SMALL_BLOCKS_DEF = 8;
    localparam int MID_BLOCKS_DEF   = 8;
    localparam int LARGE_BLOCKS_DEF = 4;
    localparam int HEADER_BYTES_DEF = 8;

    localparam int SMALL_SIZE  = 16;
    localparam int MID_SIZE    = 32;
    localparam int LARGE_SIZE  = 64;
    localparam int SMALL_SHIFT = 4;
    localparam int MID_SHIFT   = 5;
    localparam int LARGE_SHIFT = 6;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_BAD_FREE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        POOL_SMALL = 2'd0,
        POOL_MID   = 2'd1,
        POOL_LARGE = 2'd2
    } t_pool;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEC,
        S_POP
    } t_state;

    typedef struct packed {
        t_pool   pool;
        t_status status;
        logic    pop;
        logic    push;
    } t_dec;

endpackage

// ===== rtl/core/fixed_block_pool_allocator_top.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Allocator over three pools of fixed-size blocks (16, 32 and 64 bytes).
//
// Requests arrive on i_valid/o_ready with i_cmd, i_req_size, i_free_addr.
// Allocate pops the head of the first fitting pool and returns the block
// address plus the header on o_addr; free pushes the block back. Errors
// (pool empty, too large, bad free address) return a status with addr zero
// and leave the pools unchanged. Results leave on o_valid/i_ready.
// The area base is written on i_cfg_valid/o_cfg_ready; the user writes it
// only while the block idles, which the block itself does not enforce.
// Free and error results are registered from S_DEC, allocate results from
// S_POP after the registered read of the next-link RAM; a new request is
// taken only after the result is registered, one request at a time.
// A finished result sits in the output register while the next request is
// decoded; when the receiver stalls and the register is full the block
// holds in place. Reset restores every pool list to its ascending order at
// once via per-entry valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
#(
    parameter int SMALL_BLOCKS = SMALL_BLOCKS_DEF,
    parameter int MID_BLOCKS   = MID_BLOCKS_DEF,
    parameter int LARGE_BLOCKS = LARGE_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [15:0] i_req_size,
    input  logic [31:0] i_free_addr,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_addr,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_area_base
);

    localparam int TOTAL  = SMALL_BLOCKS + MID_BLOCKS + LARGE_BLOCKS;
    localparam int IDX_W  = $clog2(TOTAL + 1);
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int FIRST1 = SMALL_BLOCKS;
    localparam int FIRST2 = SMALL_BLOCKS + MID_BLOCKS;
    localparam int OFF1   = SMALL_BLOCKS * SMALL_SIZE;
    localparam int OFF2   = OFF1 + MID_BLOCKS * MID_SIZE;
    localparam int AOFF_W = $clog2(OFF2 + LARGE_BLOCKS * LARGE_SIZE + HEADER_BYTES + 1) + 1;
    localparam logic [IDX_W-1:0] NONE = '1;

    t_state                r_state, n_state;
    logic [31:0]           r_area_base;
    logic                  r_cmd;
    logic [15:0]           r_req_size;
    logic [31:0]           r_free_addr;
    logic [2:0][IDX_W-1:0] r_head;
    logic [TOTAL-1:0]      r_vld;
    t_pool                 r_pool;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_out_valid;
    logic [31:0]           r_addr;
    t_status               r_status;

    t_dec                  dec;
    logic [IDX_W-1:0]      dec_idx;
    logic                  out_free;
    logic                  accept;
    logic                  do_pop_rd;
    logic                  do_push;
    logic                  do_pop_wr;
    logic                  do_err;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]      ram_q;
    logic [IDX_W-1:0]      link;
    logic [IDX_W-1:0]      local_idx;
    logic [AOFF_W-1:0]     blk_off;

    fbpa_dec #(
        .SMALL_BLOCKS (SMALL_BLOCKS),
        .MID_BLOCKS   (MID_BLOCKS),
        .LARGE_BLOCKS (LARGE_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dec (
        .i_cmd       (r_cmd),
        .i_req_size  (r_req_size),
        .i_free_addr (r_free_addr),
        .i_area_base (r_area_base),
        .i_head      (r_head),
        .o_dec       (dec),
        .o_idx       (dec_idx)
    );

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (TOTAL)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (do_pop_rd),
        .i_raddr (dec_idx[ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;

    // next-link of the popped block, reset order until first written
    always_comb begin
        if (r_vld[r_idx[ADDR_W-1:0]]) begin
            link = ram_q;
        end else if (r_idx == IDX_W'(FIRST1 - 1) || r_idx == IDX_W'(FIRST2 - 1)
                     || r_idx == IDX_W'(TOTAL - 1)) begin
            link = NONE;
        end else begin
            link = r_idx + IDX_W'(1);
        end
    end

    always_comb begin
        unique case (r_pool)
            POOL_SMALL: begin
                local_idx = r_idx;
                blk_off   = AOFF_W'(local_idx) << SMALL_SHIFT;
            end
            POOL_MID: begin
                local_idx = r_idx - IDX_W'(FIRST1);
                blk_off   = AOFF_W'(OFF1) + (AOFF_W'(local_idx) << MID_SHIFT);
            end
            POOL_LARGE: begin
                local_idx = r_idx - IDX_W'(FIRST2);
                blk_off   = AOFF_W'(OFF2) + (AOFF_W'(local_idx) << LARGE_SHIFT);
            end
            default: begin
                local_idx = '0;
                blk_off   = '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        do_pop_rd = 1'b0;
        do_push   = 1'b0;
        do_pop_wr = 1'b0;
        do_err    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (dec.pop) begin
                    do_pop_rd = 1'b1;
                    n_state   = S_POP;
                end else if (out_free) begin
                    do_push = dec.push;
                    do_err  = !dec.push;
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                if (out_free) begin
                    do_pop_wr = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign ram_we    = do_push || do_pop_wr;
    assign ram_waddr = do_push ? dec_idx[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    assign ram_wdata = do_push ? r_head[dec.pool] : NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_area_base <= '0;
            r_head[0]   <= '0;
            r_head[1]   <= IDX_W'(FIRST1);
            r_head[2]   <= IDX_W'(FIRST2);
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_area_base <= i_cfg_area_base;
            end
            if (do_push) begin
                r_head[dec.pool]            <= dec_idx;
                r_vld[dec_idx[ADDR_W-1:0]]  <= 1'b1;
            end
            if (do_pop_wr) begin
                r_head[r_pool]              <= link;
                r_vld[r_idx[ADDR_W-1:0]]    <= 1'b1;
            end
            if (do_push || do_pop_wr || do_err) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= i_cmd;
            r_req_size  <= i_req_size;
            r_free_addr <= i_free_addr;
        end
        if (do_pop_rd) begin
            r_pool <= dec.pool;
            r_idx  <= dec_idx;
        end
        if (do_pop_wr) begin
            r_addr   <= r_area_base + 32'(blk_off) + 32'(HEADER_BYTES);
            r_status <= ST_OK;
        end else if (do_push || do_err) begin
            r_addr   <= '0;
            r_status <= dec.status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_addr   = r_addr;
    assign o_status = r_status;

endmodule

// ===== rtl/core/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fbpa_dec.sv =====
// ----------------------------------------------------------------------------
// fbpa_dec
// Request decoder: picks the pool for an allocate and checks its head, or
// maps a freed address back to its pool and block index.
// ----------------------------------------------------------------------------
module fbpa_dec
    import fbpa_pkg::*;
#(
    parameter int SMALL_BLOCKS = SMALL_BLOCKS_DEF,
    parameter int MID_BLOCKS   = MID_BLOCKS_DEF,
    parameter int LARGE_BLOCKS = LARGE_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    localparam int TOTAL = SMALL_BLOCKS + MID_BLOCKS + LARGE_BLOCKS,
    localparam int IDX_W = $clog2(TOTAL + 1)
) (
    input  logic                      i_cmd,
    input  logic [15:0]               i_req_size,
    input  logic [31:0]               i_free_addr,
    input  logic [31:0]               i_area_base,
    input  logic [2:0][IDX_W-1:0]     i_head,
    output t_dec                      o_dec,
    output logic [IDX_W-1:0]          o_idx
);

    localparam int END0  = SMALL_BLOCKS * SMALL_SIZE;
    localparam int END1  = END0 + MID_BLOCKS * MID_SIZE;
    localparam int END2  = END1 + LARGE_BLOCKS * LARGE_SIZE;
    localparam int OFF_W = $clog2(END2 + 1);
    localparam int FIRST1 = SMALL_BLOCKS;
    localparam int FIRST2 = SMALL_BLOCKS + MID_BLOCKS;
    localparam logic [IDX_W-1:0] NONE = '1;

    logic [16:0]      need;
    logic [31:0]      off;
    logic [OFF_W-1:0] off_lo;
    logic [OFF_W-1:0] rel;

    assign need   = {1'b0, i_req_size} + 17'(HEADER_BYTES);
    assign off    = i_free_addr - 32'(HEADER_BYTES) - i_area_base;
    assign off_lo = off[OFF_W-1:0];

    always_comb begin
        o_dec.pool   = POOL_SMALL;
        o_dec.status = ST_OK;
        o_dec.pop    = 1'b0;
        o_dec.push   = 1'b0;
        o_idx        = NONE;
        rel          = '0;
        if (i_cmd == CMD_ALLOC) begin
            priority if (need <= 17'(SMALL_SIZE)) begin
                o_dec.pool = POOL_SMALL;
                o_idx      = i_head[0];
            end else if (need <= 17'(MID_SIZE)) begin
                o_dec.pool = POOL_MID;
                o_idx      = i_head[1];
            end else if (need <= 17'(LARGE_SIZE)) begin
                o_dec.pool = POOL_LARGE;
                o_idx      = i_head[2];
            end else begin
                o_dec.status = ST_TOO_LARGE;
            end
            if (o_dec.status == ST_OK) begin
                if (o_idx == NONE) begin
                    o_dec.status = ST_EMPTY;
                end else begin
                    o_dec.pop = 1'b1;
                end
            end
        end else begin
            priority if (off < 32'(END0)) begin
                o_dec.pool = POOL_SMALL;
                rel        = off_lo;
                o_idx      = IDX_W'(rel >> SMALL_SHIFT);
                o_dec.push = (rel[SMALL_SHIFT-1:0] == '0);
            end else if (off < 32'(END1)) begin
                o_dec.pool = POOL_MID;
                rel        = off_lo - OFF_W'(END0);
                o_idx      = IDX_W'(FIRST1) + IDX_W'(rel >> MID_SHIFT);
                o_dec.push = (rel[MID_SHIFT-1:0] == '0);
            end else if (off < 32'(END2)) begin
                o_dec.pool = POOL_LARGE;
                rel        = off_lo - OFF_W'(END1);
                o_idx      = IDX_W'(FIRST2) + IDX_W'(rel >> LARGE_SHIFT);
                o_dec.push = (rel[LARGE_SHIFT-1:0] == '0);
            end else begin
                o_dec.push = 1'b0;
            end
            if (!o_dec.push) begin
                o_dec.status = ST_BAD_FREE;
            end
        end
    end

endmodule

// ===== sim/pool_alloc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_alloc_checker
// Watches the request, result and area base channels of the block pool
// allocator. Keeps its own free lists per pool, works out the result of each
// accepted request and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module pool_alloc_checker
    import fbpa_pkg::*;
#(
    parameter int SMALL_BLOCKS = SMALL_BLOCKS_DEF,
    parameter int MID_BLOCKS   = MID_BLOCKS_DEF,
    parameter int LARGE_BLOCKS = LARGE_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_req_cmd,
    input  logic [15:0] i_req_size,
    input  logic [31:0] i_req_free_addr,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_addr,
    input  logic [1:0]  i_res_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_area_base,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int         TOTAL_BLOCKS = SMALL_BLOCKS + MID_BLOCKS + LARGE_BLOCKS;
    localparam logic [4:0] NO_BLOCK     = 5'd31;

    typedef struct packed {
        logic [31:0] addr;
        t_status     status;
    } t_alloc_result;

    logic [31:0]   area_base;
    logic [4:0]    next_free [TOTAL_BLOCKS];
    logic [4:0]    head_free [3];
    t_alloc_result results_due [$];
    int            fail_count = 0;

    function automatic int pool_bytes(input int p);
        case (p)
            0:       return SMALL_SIZE;
            1:       return MID_SIZE;
            default: return LARGE_SIZE;
        endcase
    endfunction

    function automatic int pool_blocks(input int p);
        case (p)
            0:       return SMALL_BLOCKS;
            1:       return MID_BLOCKS;
            default: return LARGE_BLOCKS;
        endcase
    endfunction

    function automatic int pool_first(input int p);
        int idx;
        idx = 0;
        for (int q = 0; q < p; q++) idx += pool_blocks(q);
        return idx;
    endfunction

    function automatic logic [31:0] pool_start(input int p);
        logic [31:0] off;
        off = '0;
        for (int q = 0; q < p; q++) off += pool_blocks(q) * pool_bytes(q);
        return off;
    endfunction

    function automatic void reset_pools();
        int first;
        for (int p = 0; p < 3; p++) begin
            first = pool_first(p);
            head_free[p] = 5'(first);
            for (int i = 0; i < pool_blocks(p); i++) begin
                next_free[first + i] = (i + 1 < pool_blocks(p)) ? 5'(first + i + 1) : NO_BLOCK;
            end
        end
    endfunction

    function automatic t_alloc_result serve_request(input logic cmd, input logic [15:0] size,
                                                    input logic [31:0] free_addr);
        t_alloc_result r;
        logic [31:0]   off;
        logic [31:0]   rel;
        logic [4:0]    blk;
        bit            done;
        r.addr = '0;
        done   = 1'b0;
        if (cmd == CMD_ALLOC) begin
            r.status = ST_TOO_LARGE;
            for (int p = 0; p < 3; p++) begin
                if (!done && 32'(size) + HEADER_BYTES <= pool_bytes(p)) begin
                    done = 1'b1;
                    blk  = head_free[p];
                    if (blk == NO_BLOCK) begin
                        r.status = ST_EMPTY;
                    end else begin
                        head_free[p]   = next_free[blk];
                        next_free[blk] = NO_BLOCK;
                        r.status       = ST_OK;
                        r.addr = area_base + pool_start(p)
                               + 32'(blk - pool_first(p)) * pool_bytes(p) + HEADER_BYTES;
                    end
                end
            end
        end else begin
            r.status = ST_BAD_FREE;
            off = free_addr - HEADER_BYTES - area_base;
            for (int p = 0; p < 3; p++) begin
                if (!done && off >= pool_start(p)
                        && off - pool_start(p) < 32'(pool_blocks(p) * pool_bytes(p))) begin
                    done = 1'b1;
                    rel  = off - pool_start(p);
                    if (rel % pool_bytes(p) == 0) begin
                        blk            = 5'(pool_first(p) + rel / pool_bytes(p));
                        next_free[blk] = head_free[p];
                        head_free[p]   = blk;
                        r.status       = ST_OK;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void flag_failure(input string msg);
        if (fail_count < 10) $display("%t  %s", $realtime, msg);
        fail_count++;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_result due;
        if (!i_rst_n) begin
            area_base = '0;
            reset_pools();
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) area_base = i_cfg_area_base;
            if (i_res_valid && i_res_ready) begin
                if (results_due.size() == 0) begin
                    flag_failure($sformatf("result with no request due: addr %h status %0d",
                                           i_res_addr, i_res_status));
                end else begin
                    due = results_due.pop_front();
                    if (i_res_addr !== due.addr)
                        flag_failure($sformatf("addr expected %h got %h", due.addr, i_res_addr));
                    if (i_res_status !== due.status)
                        flag_failure($sformatf("status expected %0d got %0d",
                                               due.status, i_res_status));
                end
            end
            if (i_req_valid && i_req_ready)
                results_due.push_back(serve_request(i_req_cmd, i_req_size, i_req_free_addr));
        end
        o_fail_count = fail_count;
        o_pending    = results_due.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the fixed block pool allocator: a directed pass over size
// limits, pool exhaustion, double and bad frees, then random phases of
// allocate and free requests under several area bases, with bursty request
// traffic and a stalling result receiver. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb;
    import fbpa_pkg::*;

    localparam int          HDR         = HEADER_BYTES_DEF;
    localparam int          SMALL_AREA  = SMALL_SIZE * SMALL_BLOCKS_DEF;
    localparam int          LARGE_START = SMALL_AREA + MID_SIZE * MID_BLOCKS_DEF;
    localparam int          AREA_BYTES  = LARGE_START + LARGE_SIZE * LARGE_BLOCKS_DEF;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_ready;
    logic        i_cmd           = CMD_ALLOC;
    logic [15:0] i_req_size      = '0;
    logic [31:0] i_free_addr     = '0;
    logic        o_valid;
    logic        i_ready         = 1'b0;
    logic [31:0] o_addr;
    logic [1:0]  o_status;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_area_base = '0;

    int          fail_count;
    int          pending;
    logic [31:0] cur_base   = '0;
    int          stall_pct  = 0;
    int          stall_run  = 0;
    int          ready_hold = 0;
    logic        inflight_cmd [$];
    logic [31:0] live_offs [$];
    logic [31:0] freed_offs [$];

    fixed_block_pool_allocator_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_req_size      (i_req_size),
        .i_free_addr     (i_free_addr),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_addr          (o_addr),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_area_base (i_cfg_area_base)
    );

    pool_alloc_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_req_cmd       (i_cmd),
        .i_req_size      (i_req_size),
        .i_req_free_addr (i_free_addr),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_res_addr      (o_addr),
        .i_res_status    (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_area_base (i_cfg_area_base),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("fixed_block_pool_allocator_top: mismatch");
        $finish;
    end

    // receiver stalls in runs of random length
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            i_ready    <= ($urandom_range(0, 99) >= stall_pct);
            ready_hold <= $urandom_range(0, stall_run);
        end
    end

    // blocks handed out become candidates for free requests
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && i_ready && inflight_cmd.size() > 0) begin
            if (inflight_cmd.pop_front() == CMD_ALLOC && o_status == ST_OK)
                live_offs.push_back(o_addr - cur_base);
        end
    end

    task automatic push_request(input logic cmd, input logic [15:0] size,
                                input logic [31:0] free_addr);
        inflight_cmd.push_back(cmd);
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_req_size  <= size;
        i_free_addr <= free_addr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_alloc(input logic [15:0] size);
        push_request(CMD_ALLOC, size, $urandom());
    endtask

    task automatic send_free(input logic [31:0] free_addr);
        push_request(CMD_FREE, 16'($urandom_range(0, 65535)), free_addr);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_area_base(input logic [31:0] base);
        i_cfg_valid     <= 1'b1;
        i_cfg_area_base <= base;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_base = base;
    endtask

    task automatic issue_random();
        int          pick;
        int          k;
        logic [31:0] off;
        pick = $urandom_range(0, 99);
        if (pick < 45 || (pick < 85 && live_offs.size() == 0)) begin
            if ($urandom_range(0, 9) == 0) send_alloc(16'($urandom_range(57, 65535)));
            else send_alloc(16'($urandom_range(0, 56)));
        end else if (pick < 85) begin
            k   = $urandom_range(0, live_offs.size() - 1);
            off = live_offs[k];
            live_offs.delete(k);
            freed_offs.push_back(off);
            if (freed_offs.size() > 8) freed_offs.delete(0);
            send_free(cur_base + off);
        end else if (pick < 89 && freed_offs.size() > 0) begin
            // double free
            send_free(cur_base + freed_offs[$urandom_range(0, freed_offs.size() - 1)]);
        end else begin
            case ($urandom_range(0, 2))
                0:       send_free($urandom());
                1:       send_free(cur_base + HDR + $urandom_range(0, AREA_BYTES + 64));
                default: send_free(cur_base + $urandom_range(0, AREA_BYTES));
            endcase
        end
    endtask

    task automatic run_phase(input logic [31:0] base, input int pct, input int run,
                             input int gap_max, input int burst_max, input int count);
        int burst;
        settle();
        stall_pct = pct;
        stall_run = run;
        write_area_base(base);
        burst = $urandom_range(1, burst_max);
        for (int n = 0; n < count; n++) begin
            issue_random();
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, burst_max);
                if (gap_max > 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        stall_pct = 20;
        stall_run = 2;
        write_area_base(32'h0000_0000);

        // size limits of each pool
        send_alloc(16'd0);
        send_alloc(16'd8);
        send_alloc(16'd9);
        send_alloc(16'd24);
        send_alloc(16'd25);
        send_alloc(16'd56);
        send_alloc(16'd57);
        send_alloc(16'hFFFF);
        // drain the large pool
        send_alloc(16'd56);
        send_alloc(16'd56);
        send_alloc(16'd56);
        // free, double free, reuse
        send_free(HDR + LARGE_START);
        send_free(HDR + LARGE_START);
        send_alloc(16'd40);
        send_alloc(16'd40);
        // bad frees, then two valid frees of blocks in use
        send_free(32'h0000_0000);
        send_free(32'hFFFF_FFFF);
        send_free(HDR + 4);
        send_free(HDR + AREA_BYTES);
        send_free(HDR + SMALL_AREA + 16);
        send_free(HDR + SMALL_AREA + 32);
        send_free(HDR + AREA_BYTES - LARGE_SIZE);
        push_request(CMD_ALLOC, 16'd1, 32'hFFFF_FFFF);

        run_phase(32'hFFFF_FFFF, 0, 0, 0, 60, 140);
        run_phase(32'h0000_0000, 30, 3, 3, 6, 140);
        run_phase($urandom(), 60, 7, 6, 3, 140);
        run_phase(32'hFFFF_FE00, 10, 1, 2, 12, 140);
        run_phase($urandom() & 32'hFFFF_FFC0, 45, 5, 8, 4, 140);

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("fixed_block_pool_allocator_top: match");
        end else begin
            $display("fixed_block_pool_allocator_top: mismatch");
        end
        $finish;
    end

endmodule
